// ----- rtl/fspv_pkg.sv -----
// ============================================================================
// fspv_pkg
// Shared types and constants of the filesystem path validator.
// ============================================================================
package fspv_pkg;

    // field and register widths
    localparam int unsigned CH_W       = 8;
    localparam int unsigned SYS_LEN_W  = 7;
    localparam int unsigned NODE_LEN_W = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYS_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT = 2'd1;

    // register reset values
    localparam logic [SYS_LEN_W-1:0]  SYS_LIMIT_RST  = 7'd32;
    localparam logic [NODE_LEN_W-1:0] NODE_LIMIT_RST = 9'd256;

    // saturation points of the length counters
    localparam logic [SYS_LEN_W-1:0]  SYS_MAX  = '1;
    localparam logic [NODE_LEN_W-1:0] NODE_MAX = '1;

    // character codes
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_0      = 8'h30;
    localparam logic [CH_W-1:0] CH_9      = 8'h39;
    localparam logic [CH_W-1:0] CH_UA     = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ     = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA     = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ     = 8'h7A;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SYS,
        PH_GAP,
        PH_COL1,
        PH_COL2,
        PH_SKIP,
        PH_NODE
    } fspv_phase_t;

    // character class flags
    typedef struct packed {
        logic ws;
        logic space;
        logic alnum;
        logic colon;
        logic slash;
        logic dash;
        logic underscore;
        logic node_bad;
        logic lead_bad;
    } fspv_class_t;

    // configuration registers
    typedef struct packed {
        logic [SYS_LEN_W-1:0]  sys_limit;
        logic [NODE_LEN_W-1:0] node_limit;
    } fspv_cfg_t;

endpackage

// ----- rtl/fs_path_validator_core.sv -----
// ============================================================================
// fs_path_validator_core
// Streaming checker for "fsname://node/node..." paths, one byte per request,
// with a single pass/fail verdict on each end request.
// ============================================================================
//
//  channel   ports                              carries
//  --------  ---------------------------------  --------------------------------
//  input     s_valid s_ready s_ch s_end_req     path byte or end marker
//  result    m_valid m_ready m_valid_res        verdict, one per end request
//  config    cfg_we cfg_index cfg_wdata         name length limits, write only
//
//  one request per cycle sustained while no end request waits on a held verdict;
//  the input register takes an end request, then the result register loads
//  its verdict once it has room, and m_valid rises as it loads
//  synchronous active-low reset clears parser state and restores both limits
//  s_ready is low during reset
//  a held verdict only stalls the input side once an end request is waiting
//  behind it; byte requests keep flowing while the result register is full
//
module fs_path_validator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fspv_pkg::CH_W-1:0]         s_ch,
    input  logic                              s_end_req,
    // verdicts
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_valid_res,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [fspv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fspv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic [fspv_pkg::CH_W-1:0]     in_ch_reg, in_ch_next;
    logic                          in_end_reg, in_end_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_res_reg, out_res_next;

    // limits
    fspv_pkg::fspv_cfg_t           cfg_reg, cfg_next;

    fspv_pkg::fspv_class_t         cls;
    logic                          verdict;
    logic                          out_free;
    logic                          advance;
    logic                          s_take;

    // result register can take a verdict this cycle
    assign out_free = !out_valid_reg || m_ready;
    // byte requests always retire; end requests need room for the verdict
    assign advance  = in_valid_reg && (!in_end_reg || out_free);
    assign s_ready  = aresetn && (!in_valid_reg || advance);
    assign s_take   = s_valid && s_ready;

    assign m_valid     = out_valid_reg;
    assign m_valid_res = out_res_reg;

    fspv_classify u_classify (
        .ch  (in_ch_reg),
        .cls (cls)
    );

    fspv_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .end_req (in_end_reg),
        .cls     (cls),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    // input stage
    always_comb begin
        in_valid_next = in_valid_reg;
        in_ch_next    = in_ch_reg;
        in_end_next   = in_end_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            in_ch_next    = s_ch;
            in_end_next   = s_end_req;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // result stage
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance && in_end_reg) begin
            out_valid_next = 1'b1;
            out_res_next   = verdict;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // limit registers; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                fspv_pkg::CFG_SYS_LIMIT:
                    cfg_next.sys_limit  = cfg_wdata[fspv_pkg::SYS_LEN_W-1:0];
                fspv_pkg::CFG_NODE_LIMIT:
                    cfg_next.node_limit = cfg_wdata[fspv_pkg::NODE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            cfg_reg.sys_limit   <= fspv_pkg::SYS_LIMIT_RST;
            cfg_reg.node_limit  <= fspv_pkg::NODE_LIMIT_RST;
        end else begin
            in_valid_reg        <= in_valid_next;
            out_valid_reg       <= out_valid_next;
            cfg_reg             <= cfg_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_ch_reg   <= in_ch_next;
        in_end_reg  <= in_end_next;
        out_res_reg <= out_res_next;
    end

endmodule

// ----- rtl/fspv_classify.sv -----
// ============================================================================
// fspv_classify
// Character classifier for the path validator.
// ============================================================================
module fspv_classify (
    input  logic [fspv_pkg::CH_W-1:0] ch,
    output fspv_pkg::fspv_class_t     cls
);

    logic print;

    always_comb begin
        print = (ch >= fspv_pkg::CH_SPACE) && (ch <= fspv_pkg::CH_TILDE);

        cls.space      = (ch == fspv_pkg::CH_SPACE);
        cls.ws         = cls.space || ((ch >= fspv_pkg::CH_TAB) && (ch <= fspv_pkg::CH_CR));
        cls.alnum      = ((ch >= fspv_pkg::CH_0)  && (ch <= fspv_pkg::CH_9))
                      || ((ch >= fspv_pkg::CH_UA) && (ch <= fspv_pkg::CH_UZ))
                      || ((ch >= fspv_pkg::CH_LA) && (ch <= fspv_pkg::CH_LZ));
        cls.colon      = (ch == fspv_pkg::CH_COLON);
        cls.slash      = (ch == fspv_pkg::CH_SLASH);
        cls.dash       = (ch == fspv_pkg::CH_DASH);
        cls.underscore = (ch == fspv_pkg::CH_UNDER);
        // forbidden anywhere in a node name
        cls.node_bad   = !print || cls.colon || (ch == fspv_pkg::CH_SEMI)
                      || (ch == fspv_pkg::CH_TILDE) || (ch == fspv_pkg::CH_BSLASH);
        // forbidden as first node character
        cls.lead_bad   = cls.dash || (ch == fspv_pkg::CH_DOLLAR) || (ch == fspv_pkg::CH_PCT)
                      || (ch == fspv_pkg::CH_HASH) || (ch == fspv_pkg::CH_GT);
    end

endmodule

// ----- rtl/fspv_engine.sv -----
// ============================================================================
// fspv_engine
// Path parser state and its per-character update.
// ============================================================================
module fspv_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic                  end_req,
    input  fspv_pkg::fspv_class_t cls,
    input  fspv_pkg::fspv_cfg_t   cfg,
    output logic                  verdict
);

    localparam int unsigned SUM_W = fspv_pkg::NODE_LEN_W + 1;

    fspv_pkg::fspv_phase_t              phase_reg, phase_next;
    logic [fspv_pkg::SYS_LEN_W-1:0]     sys_len_reg, sys_len_next;
    logic                               sys_alnum_reg, sys_alnum_next;
    logic [fspv_pkg::NODE_LEN_W-1:0]    node_len_reg, node_len_next;
    logic [fspv_pkg::NODE_LEN_W-1:0]    pend_reg, pend_next;
    logic                               pend_np_reg, pend_np_next;
    logic                               dash_reg, dash_next;
    logic                               failed_reg, failed_next;

    logic                               sys_close_bad;
    logic                               node_close_bad;
    logic                               sys_char_bad;
    logic                               end_ok;
    logic [SUM_W-1:0]                   node_sum;
    logic [fspv_pkg::NODE_LEN_W-1:0]    nc_len;
    logic [fspv_pkg::NODE_LEN_W-1:0]    nc_pend;
    logic                               nc_np;
    logic                               nc_dash;
    logic                               nc_fail;

    // closing checks and node character effect
    always_comb begin
        sys_close_bad  = (sys_len_reg == '0) || (sys_len_reg >= cfg.sys_limit) || !sys_alnum_reg;
        node_close_bad = (node_len_reg >= cfg.node_limit) || dash_reg;
        sys_char_bad   = !cls.alnum && ((sys_len_reg == '0) || (!cls.dash && !cls.underscore));

        node_sum = SUM_W'(node_len_reg) + SUM_W'(pend_reg) + SUM_W'(1);
        if (cls.ws) begin
            nc_len  = node_len_reg;
            nc_pend = (pend_reg == fspv_pkg::NODE_MAX) ? pend_reg : pend_reg + 1'b1;
            nc_np   = pend_np_reg || !cls.space;
            nc_dash = dash_reg;
            nc_fail = 1'b0;
        end else begin
            nc_len  = node_sum[SUM_W-1] ? fspv_pkg::NODE_MAX
                                        : node_sum[fspv_pkg::NODE_LEN_W-1:0];
            nc_pend = '0;
            nc_np   = 1'b0;
            nc_dash = cls.dash;
            nc_fail = pend_np_reg || cls.node_bad;
        end
    end

    // verdict for an end request
    always_comb begin
        unique case (phase_reg)
            fspv_pkg::PH_SKIP: end_ok = 1'b1;
            fspv_pkg::PH_NODE: end_ok = !node_close_bad;
            default:           end_ok = 1'b0;
        endcase
        verdict = end_ok && !failed_reg;
    end

    // next state
    always_comb begin
        phase_next     = phase_reg;
        sys_len_next   = sys_len_reg;
        sys_alnum_next = sys_alnum_reg;
        node_len_next  = node_len_reg;
        pend_next      = pend_reg;
        pend_np_next   = pend_np_reg;
        dash_next      = dash_reg;
        failed_next    = failed_reg;

        if (step_en) begin
            if (end_req) begin
                phase_next     = fspv_pkg::PH_LEAD;
                sys_len_next   = '0;
                sys_alnum_next = 1'b0;
                node_len_next  = '0;
                pend_next      = '0;
                pend_np_next   = 1'b0;
                dash_next      = 1'b0;
                failed_next    = 1'b0;
            end else if (!failed_reg) begin
                unique case (phase_reg)
                    fspv_pkg::PH_LEAD, fspv_pkg::PH_SYS: begin
                        // leading whitespace is dropped, anything else opens the name
                        if (!(phase_reg == fspv_pkg::PH_LEAD && cls.ws)) begin
                            priority if (cls.colon) begin
                                failed_next = sys_close_bad;
                                phase_next  = fspv_pkg::PH_COL1;
                            end else if (cls.ws) begin
                                failed_next = sys_close_bad;
                                phase_next  = fspv_pkg::PH_GAP;
                            end else begin
                                phase_next     = fspv_pkg::PH_SYS;
                                failed_next    = sys_char_bad;
                                sys_alnum_next = cls.alnum;
                                if (sys_len_reg != fspv_pkg::SYS_MAX) begin
                                    sys_len_next = sys_len_reg + 1'b1;
                                end
                            end
                        end
                    end
                    fspv_pkg::PH_GAP: begin
                        if (cls.colon) begin
                            phase_next = fspv_pkg::PH_COL1;
                        end else if (!cls.ws) begin
                            failed_next = 1'b1;
                        end
                    end
                    fspv_pkg::PH_COL1: begin
                        if (cls.slash) begin
                            phase_next = fspv_pkg::PH_COL2;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    fspv_pkg::PH_COL2: begin
                        if (cls.slash) begin
                            phase_next = fspv_pkg::PH_SKIP;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    fspv_pkg::PH_SKIP: begin
                        if (!cls.ws && !cls.slash) begin
                            phase_next    = fspv_pkg::PH_NODE;
                            failed_next   = cls.lead_bad || nc_fail;
                            node_len_next = nc_len;
                            pend_next     = nc_pend;
                            pend_np_next  = nc_np;
                            dash_next     = nc_dash;
                        end
                    end
                    default: begin
                        if (cls.slash) begin
                            phase_next    = fspv_pkg::PH_SKIP;
                            failed_next   = node_close_bad;
                            node_len_next = '0;
                            pend_next     = '0;
                            pend_np_next  = 1'b0;
                            dash_next     = 1'b0;
                        end else begin
                            failed_next   = nc_fail;
                            node_len_next = nc_len;
                            pend_next     = nc_pend;
                            pend_np_next  = nc_np;
                            dash_next     = nc_dash;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= fspv_pkg::PH_LEAD;
            sys_len_reg   <= '0;
            sys_alnum_reg <= 1'b0;
            node_len_reg  <= '0;
            pend_reg      <= '0;
            pend_np_reg   <= 1'b0;
            dash_reg      <= 1'b0;
            failed_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            sys_len_reg   <= sys_len_next;
            sys_alnum_reg <= sys_alnum_next;
            node_len_reg  <= node_len_next;
            pend_reg      <= pend_next;
            pend_np_reg   <= pend_np_next;
            dash_reg      <= dash_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

// ----- rtl/fspv_checker.sv -----
// ============================================================================
// fspv_checker
// Port-level checks of the path validator, bound to the top level.
// ============================================================================
module fspv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_end_req,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_valid_res
);

    logic s_take;
    logic s_end_take;

    assign s_take     = s_valid && s_ready;
    assign s_end_take = s_take && s_end_req;

    // held verdict stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_valid_res))
        else $error("verdict changed while stalled");

    // a new verdict comes only from an earlier end request
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_end_take, 2))
        else $error("verdict without end request");

    // input stalls only behind a held verdict
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

endmodule

bind fs_path_validator_core fspv_checker u_fspv_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_end_req   (s_end_req),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_valid_res (m_valid_res)
);

// ----- dv/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for fs_path_validator_core. It streams random paths
// and broken or noisy strings one byte per request, under several name
// length limits and back-pressure patterns. A behavioral path checker
// predicts each verdict, and the bench compares every verdict in order.
// ============================================================================
module tb;
    import fspv_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 6;     // settling margin after the last verdict
    localparam int HOLD_CYCLES  = 400;   // long receiver stall to back up the input side

    // the block ignores writes to these indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            fin;
    } path_req_t;

    // ------------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [CH_W-1:0]       s_ch      = '0;
    logic                  s_end_req = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_valid_res;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fs_path_validator_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .s_end_req   (s_end_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    path_req_t pending_q[$];   // requests waiting to be offered
    bit        verdict_q[$];   // predicted verdicts, oldest first

    int pushed_count  = 0;
    int req_count     = 0;
    int verdict_count = 0;
    int pass_count    = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 65;

    // long receiver stall, armed once by the sequence, timed by the ready process
    bit hold_arm  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // limits as the block should currently hold them
    logic [SYS_LEN_W-1:0]  sys_limit_q  = SYS_LIMIT_RST;
    logic [NODE_LEN_W-1:0] node_limit_q = NODE_LIMIT_RST;

    // path checker state
    fspv_phase_t           p_phase         = PH_LEAD;
    logic [SYS_LEN_W-1:0]  p_sys_len       = '0;
    bit                    p_sys_end_alnum = 1'b0;
    logic [NODE_LEN_W-1:0] p_node_len      = '0;
    logic [NODE_LEN_W-1:0] p_trail_ws      = '0;   // whitespace not yet known to be inner
    bit                    p_trail_ctl     = 1'b0; // that whitespace holds a control char
    bit                    p_node_end_dash = 1'b0;
    bit                    p_broken        = 1'b0; // sticky until the end request

    bit        drv_has_v;
    bit        drv_v;
    path_req_t drv_next;
    bit        mon_exp;

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic bit is_ws(input logic [CH_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_alnum(input logic [CH_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_LA && c <= CH_LZ);
    endfunction

    function automatic bit is_print(input logic [CH_W-1:0] c);
        return c >= CH_SPACE && c <= CH_TILDE;
    endfunction

    // ------------------------------------------------------------------------
    // path checker
    // ------------------------------------------------------------------------
    task automatic clear_path();
        p_phase         = PH_LEAD;
        p_sys_len       = '0;
        p_sys_end_alnum = 1'b0;
        p_node_len      = '0;
        p_trail_ws      = '0;
        p_trail_ctl     = 1'b0;
        p_node_end_dash = 1'b0;
        p_broken        = 1'b0;
    endtask

    task automatic close_fs_name();
        if (p_sys_len == 0 || p_sys_len >= sys_limit_q || !p_sys_end_alnum) begin
            p_broken = 1'b1;
        end
    endtask

    // trailing whitespace is dropped here, so it never counts or fails
    task automatic close_node();
        if (p_node_len >= node_limit_q || p_node_end_dash) begin
            p_broken = 1'b1;
        end
        p_node_len      = '0;
        p_trail_ws      = '0;
        p_trail_ctl     = 1'b0;
        p_node_end_dash = 1'b0;
    endtask

    task automatic node_byte(input logic [CH_W-1:0] c);
        int sum;
        if (is_ws(c)) begin
            if (p_trail_ws < NODE_MAX) begin
                p_trail_ws++;
            end
            if (c != CH_SPACE) begin
                p_trail_ctl = 1'b1;
            end
        end else begin
            // held whitespace turns out to be inner: spaces count, others fail
            if (p_trail_ctl) begin
                p_broken = 1'b1;
            end
            sum = int'(p_node_len) + int'(p_trail_ws) + 1;
            p_node_len = (sum > int'(NODE_MAX)) ? NODE_MAX : NODE_LEN_W'(sum);
            p_trail_ws  = '0;
            p_trail_ctl = 1'b0;
            if (!is_print(c) || c == CH_COLON || c == CH_SEMI || c == CH_TILDE ||
                    c == CH_BSLASH) begin
                p_broken = 1'b1;
            end
            p_node_end_dash = (c == CH_DASH);
        end
    endtask

    task automatic predict_verdict(input logic [CH_W-1:0] c, input logic fin,
                                   output bit has_v, output bit v);
        bit an;
        bit closed_ok;
        has_v = 1'b0;
        v     = 1'b0;
        if (fin) begin
            closed_ok = (p_phase == PH_SKIP);
            if (p_phase == PH_NODE) begin
                close_node();
                closed_ok = 1'b1;
            end
            has_v = 1'b1;
            v     = closed_ok && !p_broken;
            clear_path();
        end else if (!p_broken) begin
            // the first non-blank byte already belongs to the name
            if (p_phase == PH_LEAD && !is_ws(c)) begin
                p_phase = PH_SYS;
            end
            case (p_phase)
                PH_SYS: begin
                    if (c == CH_COLON) begin
                        close_fs_name();
                        p_phase = PH_COL1;
                    end else if (is_ws(c)) begin
                        close_fs_name();
                        p_phase = PH_GAP;
                    end else begin
                        an = is_alnum(c);
                        if (p_sys_len == 0 && !an) begin
                            p_broken = 1'b1;
                        end else if (!an && c != CH_DASH && c != CH_UNDER) begin
                            p_broken = 1'b1;
                        end
                        p_sys_end_alnum = an;
                        if (p_sys_len < SYS_MAX) begin
                            p_sys_len++;
                        end
                    end
                end
                PH_GAP: begin
                    if (c == CH_COLON) begin
                        p_phase = PH_COL1;
                    end else if (!is_ws(c)) begin
                        p_broken = 1'b1;
                    end
                end
                PH_COL1: begin
                    if (c == CH_SLASH) begin
                        p_phase = PH_COL2;
                    end else begin
                        p_broken = 1'b1;
                    end
                end
                PH_COL2: begin
                    if (c == CH_SLASH) begin
                        p_phase = PH_SKIP;
                    end else begin
                        p_broken = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (!is_ws(c) && c != CH_SLASH) begin
                        if (c == CH_DASH || c == CH_DOLLAR || c == CH_PCT || c == CH_HASH ||
                                c == CH_GT) begin
                            p_broken = 1'b1;
                        end
                        p_phase = PH_NODE;
                        node_byte(c);
                    end
                end
                PH_NODE: begin
                    if (c == CH_SLASH) begin
                        close_node();
                        p_phase = PH_SKIP;
                    end else begin
                        node_byte(c);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued requests, predicts on every accepted one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_verdict(s_ch, s_end_req, drv_has_v, drv_v);
                if (drv_has_v) begin
                    verdict_q.push_back(drv_v);
                end
                req_count++;
            end
            // a new request only once the slot is free, so valid never drops early
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_next = pending_q.pop_front();
                    s_valid   <= 1'b1;
                    s_ch      <= drv_next.ch;
                    s_end_req <= drv_next.fin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver ready, with the one-time long stall
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every taken verdict against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                err_count++;
                $display("%0t: verdict with no path pending, expected none, got %0b",
                         $time, m_valid_res);
            end else begin
                mon_exp = verdict_q.pop_front();
                verdict_count++;
                if (mon_exp) begin
                    pass_count++;
                end
                if (m_valid_res !== mon_exp) begin
                    err_count++;
                    $display("%0t: verdict mismatch, expected %0b, got %0b",
                             $time, mon_exp, m_valid_res);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d verdicts still pending", $time, verdict_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------------
    task automatic push_ch(input logic [CH_W-1:0] c);
        pending_q.push_back('{ch: c, fin: 1'b0});
        pushed_count++;
    endtask

    // byte lane carries junk on an end request, the block must ignore it
    task automatic push_end();
        pending_q.push_back('{ch: CH_W'($urandom), fin: 1'b1});
        pushed_count++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_ch(s[i]);
        end
    endtask

    function automatic logic [CH_W-1:0] pick_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + CH_W'(r);
    endfunction

    function automatic logic [CH_W-1:0] pick_alnum();
        case ($urandom_range(0, 2))
            0:       return CH_0 + CH_W'($urandom_range(0, 9));
            1:       return CH_UA + CH_W'($urandom_range(0, 25));
            default: return CH_LA + CH_W'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_joiner();
        return $urandom_range(0, 1) ? CH_DASH : CH_UNDER;
    endfunction

    // printable, not blank, none of the forbidden node bytes
    function automatic logic [CH_W-1:0] pick_node_char();
        logic [CH_W-1:0] c;
        do begin
            c = CH_W'($urandom_range(8'h21, 8'h7E));
        end while (c == CH_COLON || c == CH_SLASH || c == CH_SEMI || c == CH_TILDE ||
                   c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] pick_lead_bad();
        case ($urandom_range(0, 4))
            0:       return CH_DASH;
            1:       return CH_DOLLAR;
            2:       return CH_PCT;
            3:       return CH_HASH;
            default: return CH_GT;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_bad_node();
        case ($urandom_range(0, 5))
            0:       return CH_COLON;
            1:       return CH_SEMI;
            2:       return CH_TILDE;
            3:       return CH_BSLASH;
            4:       return CH_W'($urandom_range(0, 8));
            default: return CH_W'($urandom_range(8'h7F, 8'hFF));
        endcase
    endfunction

    // mostly short names, sometimes right at the limit boundary
    function automatic int pick_len(input int limit, input int short_max);
        int n;
        if (limit <= 64 && $urandom_range(0, 99) < 20) begin
            n = limit - 1 + $urandom_range(0, 1);
            if (n < 1) begin
                n = 1;
            end
        end else begin
            n = $urandom_range(1, short_max);
        end
        return n;
    endfunction

    // one path: mostly well formed with random content, some flawed, some noise
    task automatic gen_path();
        int flaw;
        int nodes;
        int len;
        logic [CH_W-1:0] c;
        flaw = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 9) : 0;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 8)) push_ch(CH_W'($urandom));
            push_end();
            return;
        end
        repeat ($urandom_range(0, 2)) push_ch(pick_ws());

        // filesystem name
        len = pick_len(sys_limit_q, 6);
        for (int k = 0; k < len; k++) begin
            if (k == 0 || k == len - 1) begin
                c = pick_alnum();
            end else begin
                c = ($urandom_range(0, 4) == 0) ? pick_joiner() : pick_alnum();
            end
            if (flaw == 1 && k == 0) begin
                c = $urandom_range(0, 1) ? pick_joiner() : CH_W'($urandom);
            end
            if (flaw == 2 && k == len - 1) begin
                c = pick_joiner();
            end
            if (flaw == 3 && k == len / 2) begin
                c = CH_W'($urandom);
            end
            push_ch(c);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) push_ch(pick_ws());
        end

        // separator, possibly cut short or mangled
        if (flaw == 4) begin
            push_ch(CH_COLON);
            if ($urandom_range(0, 1)) begin
                push_ch(CH_SLASH);
            end
            push_end();
            return;
        end
        push_ch(CH_COLON);
        push_ch(flaw == 5 ? pick_node_char() : CH_SLASH);
        push_ch(CH_SLASH);

        // nodes, flaws land in the first one
        nodes = $urandom_range(0, 3);
        for (int n = 0; n < nodes; n++) begin
            if (n > 0) begin
                push_ch(CH_SLASH);
            end
            repeat ($urandom_range(0, 2)) push_ch($urandom_range(0, 1) ? CH_SLASH : pick_ws());
            len = pick_len(node_limit_q, 5);
            for (int k = 0; k < len; k++) begin
                if (k > 0 && k < len - 1 && $urandom_range(0, 6) == 0) begin
                    c = CH_SPACE;
                end else begin
                    c = pick_node_char();
                end
                if (n == 0) begin
                    if (flaw == 6 && k == 0) begin
                        c = pick_lead_bad();
                    end
                    if (flaw == 7 && k == len - 1) begin
                        c = CH_DASH;
                    end
                    if (flaw == 8 && k == len / 2) begin
                        c = pick_bad_node();
                    end
                    if (flaw == 9 && k == len / 2 && k > 0) begin
                        c = pick_ws();
                    end
                end
                push_ch(c);
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) push_ch(pick_ws());
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            push_ch(CH_SLASH);
        end
        push_end();
    endtask

    task automatic gen_paths(input int n_req);
        int start;
        start = pushed_count;
        while (pushed_count - start < n_req) begin
            gen_path();
        end
    endtask

    // ------------------------------------------------------------------------
    // configuration, only while nothing is in flight
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == CFG_SYS_LIMIT) begin
            sys_limit_q = data[SYS_LEN_W-1:0];
        end else if (idx == CFG_NODE_LIMIT) begin
            node_limit_q = data;
        end
    endtask

    // upper data bits above the 7-bit register get junk, the block drops them
    task automatic set_limits(input int sys_lim, input int node_lim);
        write_reg(CFG_SYS_LIMIT, CFG_DATA_W'(sys_lim) |
                  (CFG_DATA_W'($urandom_range(0, 3)) << SYS_LEN_W));
        write_reg(CFG_NODE_LIMIT, CFG_DATA_W'(node_lim));
        cfg_we <= 1'b0;
    endtask

    // all requests taken, all verdicts seen, then let the pipeline settle
    task automatic drain();
        while (req_count != pushed_count || verdict_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset limits
        push_str("a://");                // end right after the separator
        push_end();
        push_str("a:");                  // end before the separator is complete
        push_end();
        push_str("\tZ9 ://~");           // leading blank, gap before colon, bad node byte
        push_end();
        push_ch(8'h00);                  // byte extremes as the first name byte
        push_ch(8'hFF);
        push_end();
        push_str("b:// /y \t");          // skipped separators, trailing blanks trimmed
        push_end();
        drain();

        // tightest legal limits
        set_limits(2, 2);
        gen_paths(90);
        drain();

        // widest legal limits, one node exactly at the node limit
        set_limits(64, 256);
        push_str("fs://");
        repeat (256) push_ch(pick_node_char());
        push_end();
        gen_paths(90);
        drain();

        // limits below range reject every name; writes to spare indexes are ignored
        send_idle_pct = 65;
        recv_idle_pct = 31;
        write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
        set_limits($urandom_range(0, 1), $urandom_range(0, 1));
        gen_paths(50);
        drain();

        // random limits, with the receiver stalled long enough to back up the input
        set_limits($urandom_range(2, 64), $urandom_range(2, 40));
        gen_paths(100);
        hold_arm = 1'b1;
        drain();

        // register maxima and saturating counters, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(127, 511);
        repeat (130) push_ch(pick_alnum());
        push_str("://a");
        push_end();
        push_str("x://");
        repeat (520) push_ch(pick_node_char());
        push_end();
        gen_paths(60);
        drain();

        // random limits anywhere in range
        set_limits($urandom_range(2, 64), $urandom_range(2, 256));
        gen_paths(90);
        drain();

        $display("summary: %0d requests taken, %0d verdicts checked (%0d valid, %0d rejected)",
                 req_count, verdict_count, pass_count, verdict_count - pass_count);
        $display("summary: limits at reset, minimum, maximum, below range and random");
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
